[rtl/core/wpci_pkg.sv]
// Shared constants, types and arithmetic helpers of the pulse charge integrator.
`timescale 1ns / 1ps
`default_nettype none

package wpci_pkg;

	localparam int NUM_CH       = 4;
	localparam int CH_W         = 2;
	localparam int SAMPLE_W     = 14;
	localparam int INDEX_W      = 12;
	localparam int START_W      = 12;
	localparam int RECORD_MAX   = 4096;
	localparam int BASELINE_LEN = 50;
	localparam int INTEGRAL_LEN = 200;

	localparam int SUM_W    = 20;
	localparam int PAIR_W   = SUM_W + 1;
	localparam int INTEG_W  = 22;
	localparam int MIN_W    = 15;
	localparam int AVG_W    = 22;
	localparam int CHARGE_W = 23;
	localparam int HEIGHT_W = 24;
	localparam int FRAC_W   = 8;

	localparam logic [MIN_W-1:0]   NO_MIN        = MIN_W'(16384);
	localparam logic [START_W-1:0] TRG_START_RST = START_W'(300);
	localparam logic [START_W-1:0] LED_START_RST = START_W'(950);

	// Configuration register indexes.
	typedef enum logic {
		CFG_TRG_START = 1'b0,
		CFG_LED_START = 1'b1
	} cfg_reg_t;

	// Window that a sample index falls in, relative to one pulse.
	typedef enum logic [1:0] {
		WIN_NONE,
		WIN_PRE,
		WIN_INT,
		WIN_POST
	} win_t;

	localparam int WIN_W = START_W + 1;

	function automatic win_t window_of(input logic [INDEX_W-1:0] j,
			input logic [START_W-1:0] s);
		logic [WIN_W-1:0] jx;
		logic [WIN_W-1:0] sx;
		jx = WIN_W'(j);
		sx = WIN_W'(s);
		if (jx < sx) begin
			return WIN_NONE;
		end else if (jx < sx + WIN_W'(BASELINE_LEN)) begin
			return WIN_PRE;
		end else if (jx < sx + WIN_W'(BASELINE_LEN + INTEGRAL_LEN)) begin
			return WIN_INT;
		end else if (jx < sx + WIN_W'(2 * BASELINE_LEN + INTEGRAL_LEN)) begin
			return WIN_POST;
		end
		return WIN_NONE;
	endfunction

	// Division by the baseline length through an exact reciprocal multiply.
	localparam int DIV_XW = SUM_W + FRAC_W;
	localparam int DIV_K  = DIV_XW + $clog2(BASELINE_LEN);
	localparam int DIV_MW = DIV_K - $clog2(BASELINE_LEN) + 1;
	localparam int DIV_PW = DIV_XW + DIV_MW;
	localparam logic [DIV_MW-1:0] DIV_M =
		DIV_MW'(((64'd1 << DIV_K) + 64'(BASELINE_LEN) - 64'd1) / 64'(BASELINE_LEN));

	function automatic logic [AVG_W-1:0] div_base(input logic [DIV_XW-1:0] x);
		logic [DIV_PW-1:0] p;
		p = DIV_PW'(x) * DIV_PW'(DIV_M);
		return p[DIV_K +: AVG_W];
	endfunction

	// Per-channel record state.
	typedef struct packed {
		logic [SUM_W-1:0]   pre_trg;
		logic [SUM_W-1:0]   post_trg;
		logic [SUM_W-1:0]   pre_led;
		logic [SUM_W-1:0]   post_led;
		logic [INTEG_W-1:0] trg_int;
		logic [INTEG_W-1:0] led_int;
		logic [MIN_W-1:0]   trg_min;
		logic [MIN_W-1:0]   led_min;
		logic [INDEX_W-1:0] trg_pos;
		logic [INDEX_W-1:0] led_pos;
	} acc_t;

	function automatic acc_t acc_clear();
		acc_t a;
		a = '0;
		a.trg_min = NO_MIN;
		a.led_min = NO_MIN;
		return a;
	endfunction

endpackage

`default_nettype wire

[rtl/core/windowed_pulse_charge_integrator.sv]
// Top level of the windowed pulse charge integrator.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Carries
// input     in         in_valid / in_ready     four channel samples and record_end
// output    out        out_valid / out_ready   one channel's pulse parameters
// config    in         cfg_we (no wait)        window start indexes
//
// One item is taken every cycle while the output drains. An item passes an input
// register and updates the accumulators in the next cycle; an item marked record_end
// copies the final accumulators into a snapshot, which feeds four results, one a cycle,
// through a two-stage output pipe (reciprocal multiply, then subtract).
// The input stalls only while an item marked record_end waits for the snapshot, which
// hands out one channel per cycle while out_ready lets the pipe move; with a free output,
// record ends four or more items apart never stall. Reset clears all record state.

module windowed_pulse_charge_integrator
	import wpci_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [START_W-1:0]         cfg_wdata,

	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [SAMPLE_W-1:0]        sample_ch0,
	input  wire logic [SAMPLE_W-1:0]        sample_ch1,
	input  wire logic [SAMPLE_W-1:0]        sample_ch2,
	input  wire logic [SAMPLE_W-1:0]        sample_ch3,
	input  wire logic                       record_end,

	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [CH_W-1:0]                 channel,
	output logic [AVG_W-1:0]                pre_trigger_avg,
	output logic [AVG_W-1:0]                post_trigger_avg,
	output logic [AVG_W-1:0]                pre_led_avg,
	output logic [AVG_W-1:0]                post_led_avg,
	output logic signed [CHARGE_W-1:0]      trigger_charge,
	output logic signed [CHARGE_W-1:0]      led_charge,
	output logic signed [HEIGHT_W-1:0]      trigger_height,
	output logic signed [HEIGHT_W-1:0]      led_height,
	output logic [INDEX_W-1:0]              trigger_min_index,
	output logic [INDEX_W-1:0]              led_min_index,
	output logic                            last_of_record
);

	// Configuration registers.
	logic [START_W-1:0] trg_start_q;
	logic [START_W-1:0] led_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trg_start_q <= TRG_START_RST;
			led_start_q <= LED_START_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TRG_START: trg_start_q <= cfg_wdata;
				CFG_LED_START: led_start_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register.
	logic                valid_s1;
	logic                rec_end_s1;
	logic [SAMPLE_W-1:0] samp_s1 [NUM_CH];

	// Snapshot and output pipe control.
	logic            snap_full_q;
	logic [CH_W-1:0] ch_q;
	logic            valid_s2;
	logic            valid_s3;
	logic            adv;
	logic            snap_free;
	logic            s1_go;

	// The whole output pipe moves together; it holds only when a result is refused.
	assign adv       = !valid_s3 || out_ready;
	// The snapshot can take a new record now, or in the same cycle it hands out
	// its last channel.
	assign snap_free = !snap_full_q || (adv && ch_q == CH_W'(NUM_CH - 1));
	assign s1_go     = valid_s1 && (!rec_end_s1 || snap_free);
	assign in_ready  = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			samp_s1[0] <= sample_ch0;
			samp_s1[1] <= sample_ch1;
			samp_s1[2] <= sample_ch2;
			samp_s1[3] <= sample_ch3;
			rec_end_s1 <= record_end;
		end
	end

	// Record accumulators. The index stops at the record length; later samples of an
	// overlong record are dropped until its end marker.
	logic [INDEX_W-1:0] idx_q;
	logic               rec_full_q;
	acc_t               acc_q [NUM_CH];
	acc_t               acc_d [NUM_CH];
	win_t               tw;
	win_t               lw;

	always_comb begin
		tw = window_of(idx_q, trg_start_q);
		// The trigger windows win where the two pulses overlap.
		lw = (tw == WIN_NONE) ? window_of(idx_q, led_start_q) : WIN_NONE;
		for (int c = 0; c < NUM_CH; c++) begin
			acc_d[c] = acc_q[c];
			if (!rec_full_q) begin
				if (tw == WIN_PRE) begin
					acc_d[c].pre_trg = acc_q[c].pre_trg + SUM_W'(samp_s1[c]);
				end else if (tw == WIN_INT) begin
					acc_d[c].trg_int = acc_q[c].trg_int + INTEG_W'(samp_s1[c]);
					// Strictly smaller only, so the first minimum is kept.
					if (MIN_W'(samp_s1[c]) < acc_q[c].trg_min) begin
						acc_d[c].trg_min = MIN_W'(samp_s1[c]);
						acc_d[c].trg_pos = idx_q;
					end
				end else if (tw == WIN_POST) begin
					acc_d[c].post_trg = acc_q[c].post_trg + SUM_W'(samp_s1[c]);
				end else if (lw == WIN_PRE) begin
					acc_d[c].pre_led = acc_q[c].pre_led + SUM_W'(samp_s1[c]);
				end else if (lw == WIN_INT) begin
					acc_d[c].led_int = acc_q[c].led_int + INTEG_W'(samp_s1[c]);
					if (MIN_W'(samp_s1[c]) < acc_q[c].led_min) begin
						acc_d[c].led_min = MIN_W'(samp_s1[c]);
						acc_d[c].led_pos = idx_q;
					end
				end else if (lw == WIN_POST) begin
					acc_d[c].post_led = acc_q[c].post_led + SUM_W'(samp_s1[c]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rec_full_q <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				acc_q[c] <= acc_clear();
			end
		end else if (s1_go) begin
			if (rec_end_s1) begin
				idx_q      <= '0;
				rec_full_q <= 1'b0;
				for (int c = 0; c < NUM_CH; c++) begin
					acc_q[c] <= acc_clear();
				end
			end else begin
				for (int c = 0; c < NUM_CH; c++) begin
					acc_q[c] <= acc_d[c];
				end
				if (!rec_full_q) begin
					if (idx_q == INDEX_W'(RECORD_MAX - 1)) begin
						rec_full_q <= 1'b1;
					end else begin
						idx_q <= idx_q + INDEX_W'(1);
					end
				end
			end
		end
	end

	// Snapshot of a finished record, read out one channel at a time.
	acc_t snap_q [NUM_CH];

	always_ff @(posedge clk) begin
		if (s1_go && rec_end_s1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				snap_q[c] <= acc_d[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_full_q <= 1'b0;
			ch_q        <= '0;
		end else begin
			if (adv && snap_full_q) begin
				ch_q <= ch_q + CH_W'(1);
				if (ch_q == CH_W'(NUM_CH - 1)) begin
					snap_full_q <= 1'b0;
				end
			end
			// A new record takes the snapshot; this wins over the drain above.
			if (s1_go && rec_end_s1) begin
				snap_full_q <= 1'b1;
				ch_q        <= '0;
			end
		end
	end

	// Stage 2: divide the baseline sums by the window length and form the charges.
	acc_t              cur;
	logic [PAIR_W-1:0] pair_trg;
	logic [PAIR_W-1:0] pair_led;

	assign cur      = snap_q[ch_q];
	assign pair_trg = PAIR_W'(cur.pre_trg) + PAIR_W'(cur.post_trg);
	assign pair_led = PAIR_W'(cur.pre_led) + PAIR_W'(cur.post_led);

	logic [CH_W-1:0]     ch_s2;
	logic                last_s2;
	logic [AVG_W-1:0]    pre_trg_avg_s2;
	logic [AVG_W-1:0]    post_trg_avg_s2;
	logic [AVG_W-1:0]    pre_led_avg_s2;
	logic [AVG_W-1:0]    post_led_avg_s2;
	logic [AVG_W-1:0]    base_trg_s2;
	logic [AVG_W-1:0]    base_led_s2;
	logic [CHARGE_W-1:0] charge_trg_s2;
	logic [CHARGE_W-1:0] charge_led_s2;
	logic [MIN_W-1:0]    min_trg_s2;
	logic [MIN_W-1:0]    min_led_s2;
	logic [INDEX_W-1:0]  pos_trg_s2;
	logic [INDEX_W-1:0]  pos_led_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= snap_full_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2           <= ch_q;
			last_s2         <= (ch_q == CH_W'(NUM_CH - 1));
			pre_trg_avg_s2  <= div_base({cur.pre_trg, FRAC_W'(0)});
			post_trg_avg_s2 <= div_base({cur.post_trg, FRAC_W'(0)});
			pre_led_avg_s2  <= div_base({cur.pre_led, FRAC_W'(0)});
			post_led_avg_s2 <= div_base({cur.post_led, FRAC_W'(0)});
			// The sum of both baselines over twice the length, at the same scale as the averages.
			base_trg_s2     <= div_base({pair_trg, (FRAC_W - 1)'(0)});
			base_led_s2     <= div_base({pair_led, (FRAC_W - 1)'(0)});
			charge_trg_s2   <= CHARGE_W'({pair_trg, 1'b0}) - CHARGE_W'(cur.trg_int);
			charge_led_s2   <= CHARGE_W'({pair_led, 1'b0}) - CHARGE_W'(cur.led_int);
			min_trg_s2      <= cur.trg_min;
			min_led_s2      <= cur.led_min;
			pos_trg_s2      <= cur.trg_pos;
			pos_led_s2      <= cur.led_pos;
		end
	end

	// Stage 3: pulse heights, and the result register that faces the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			channel           <= ch_s2;
			last_of_record    <= last_s2;
			pre_trigger_avg   <= pre_trg_avg_s2;
			post_trigger_avg  <= post_trg_avg_s2;
			pre_led_avg       <= pre_led_avg_s2;
			post_led_avg      <= post_led_avg_s2;
			trigger_charge    <= charge_trg_s2;
			led_charge        <= charge_led_s2;
			trigger_height    <= HEIGHT_W'(base_trg_s2)
				- HEIGHT_W'({min_trg_s2, FRAC_W'(0)});
			led_height        <= HEIGHT_W'(base_led_s2)
				- HEIGHT_W'({min_led_s2, FRAC_W'(0)});
			trigger_min_index <= pos_trg_s2;
			led_min_index     <= pos_led_s2;
		end
	end

	assign out_valid = valid_s3;

endmodule

`default_nettype wire

[rtl/core/wpci_checker.sv]
// Port-level assertions for the pulse charge integrator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module wpci_checker
	import wpci_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [CH_W-1:0]       channel,
	input wire logic signed [CHARGE_W-1:0] trigger_charge,
	input wire logic                  last_of_record
);

	// The record's last item is the highest channel and only that one.
	a_last_is_top_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_record == (channel == CH_W'(NUM_CH - 1))))
		else $error("last_of_record does not match the channel number");

	// Within a record, channels follow each other with no gap.
	a_channels_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_record
		|=> out_valid && channel == CH_W'($past(channel) + CH_W'(1)))
		else $error("channel sequence broken within a record");

	// After a record's last item, the next item opens a record at channel zero.
	a_new_record_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_record |=> !out_valid || channel == '0)
		else $error("record did not start at channel zero");

	// A refused item holds.
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready
		|=> out_valid && $stable(channel) && $stable(trigger_charge))
		else $error("output item changed while stalled");

endmodule

bind windowed_pulse_charge_integrator wpci_checker u_wpci_checker (.*);

`default_nettype wire
